// ----- hdl/dcmfm_pkg.sv -----
// ----------------------------------------------------------------------------
// dcmfm_pkg
// Shared widths, constants and types for the dual-channel moisture meter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcmfm_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int LIMIT_WIDTH = 24;
   localparam int FIELD_WIDTH = 24;
   localparam int QUOT_WIDTH  = 14;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
   localparam int PROD_WIDTH  = COUNT_WIDTH + QUOT_WIDTH;
   localparam int WORK_WIDTH  = COUNT_WIDTH + 1 + QUOT_WIDTH;
   localparam int STEP_WIDTH  = $clog2(QUOT_WIDTH);

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(200000);
   localparam logic [QUOT_WIDTH-1:0]  SCALE       = QUOT_WIDTH'(10000);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic                   flag;
   } chan_type;

endpackage

`default_nettype wire

// ----- hdl/dcmfm_counter.sv -----
// ----------------------------------------------------------------------------
// dcmfm_counter
// Rising-edge counter for one oscillator channel, saturating, with a sticky
// over-limit flag. Clears at the end of each window.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmfm_counter
   import dcmfm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic                   level,
   input  wire logic                   window_end,
   input  wire logic [LIMIT_WIDTH-1:0] limit,
   output chan_type                    chan_next
);

   logic                   prev_ff;
   logic [COUNT_WIDTH-1:0] edges_ff;
   logic                   flag_ff;
   logic                   rise;
   logic [COUNT_WIDTH-1:0] edges_in;
   logic                   flag_in;

   always_comb begin
      rise     = !prev_ff && level;
      edges_in = edges_ff;
      if (rise && (edges_ff != COUNT_MAX)) begin
         edges_in = edges_ff + COUNT_WIDTH'(1);
      end
      flag_in = flag_ff || (rise && (CMP_WIDTH'(edges_in) > CMP_WIDTH'(limit)));
      chan_next.count = edges_in;
      chan_next.flag  = flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b1;
         edges_ff <= '0;
         flag_ff  <= 1'b0;
      end else if (accept) begin
         prev_ff <= level;
         if (window_end) begin
            edges_ff <= '0;
            flag_ff  <= 1'b0;
         end else begin
            edges_ff <= edges_in;
            flag_ff  <= flag_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/dcmfm_divider.sv -----
// ----------------------------------------------------------------------------
// dcmfm_divider
// Moisture ratio unit: one constant multiply, then a restoring divide that
// resolves one quotient bit per cycle through a single subtract/compare.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmfm_divider
   import dcmfm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [COUNT_WIDTH-1:0] soil,
   input  wire logic [COUNT_WIDTH-1:0] air,
   output logic                        done,
   output logic [QUOT_WIDTH-1:0]       quotient
);

   logic                    running_ff;
   logic                    done_ff;
   logic [STEP_WIDTH-1:0]   step_ff;
   logic [WORK_WIDTH-1:0]   work_ff;
   logic [WORK_WIDTH-1:0]   work_in;
   logic [COUNT_WIDTH-1:0]  diff;
   logic [PROD_WIDTH-1:0]   product;
   logic [WORK_WIDTH-1:0]   shifted;
   logic [COUNT_WIDTH:0]    top;
   logic [COUNT_WIDTH:0]    divisor;

   always_comb begin
      diff    = (soil < air) ? (air - soil) : '0;
      product = PROD_WIDTH'(diff) * PROD_WIDTH'(SCALE);
      shifted = work_ff << 1;
      top     = shifted[WORK_WIDTH-1:QUOT_WIDTH];
      divisor = {1'b0, air};
      work_in = shifted;
      if (top >= divisor) begin
         work_in[WORK_WIDTH-1:QUOT_WIDTH] = top - divisor;
         work_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         step_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            running_ff <= 1'b1;
            step_ff    <= '0;
         end else if (running_ff) begin
            step_ff <= step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(QUOT_WIDTH - 1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= {1'b0, product};
      end else if (running_ff) begin
         work_ff <= work_in;
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff[QUOT_WIDTH-1:0];

endmodule

`default_nettype wire

// ----- hdl/dual_channel_moisture_frequency_meter.sv -----
// ----------------------------------------------------------------------------
// dual_channel_moisture_frequency_meter
// Counts rising edges of a soil-probe and an air-reference oscillator over a
// window and reports both counts and the moisture ratio at window end.
//
// req channel: one transaction per sample tick; tdata[0] soil level,
// tdata[1] air level, tlast marks the last tick of the window.
// rsp channel: one transaction per window, carrying counts, moisture and
// flags. csr port: overflow_limit at address 0.
// Ticks without tlast are taken one per cycle while the sequencer is idle. A
// window-end tick starts the ratio unit: a registered start loads the
// product, the restoring divider resolves one quotient bit per cycle, done
// is registered, then the result register is loaded, so rsp_tvalid rises
// and the next tick is taken once rsp is free.
// While a result waits in the rsp register, ordinary ticks keep being taken;
// a further window end waits in the final stage until rsp_tready drains it.
// Reset clears counts and flags, sets the level history to high and the
// limit to 200000.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_channel_moisture_frequency_meter
   import dcmfm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // [0] soil_level, [1] air_level
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [23:0] soil_count, [47:24] air_count, [61:48] moisture_centipercent
   output logic [63:0]      rsp_tdata,
   // [0] soil_overflow, [1] air_overflow, [2] reading_valid
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic REG_LIMIT = 1'b0;

   logic [1:0]             state_ff;
   logic [1:0]             state_in;
   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic [COUNT_WIDTH-1:0] snap_soil_ff;
   logic [COUNT_WIDTH-1:0] snap_air_ff;
   logic                   snap_soil_flag_ff;
   logic                   snap_air_flag_ff;
   logic                   start_ff;
   logic                   rsp_tvalid_ff;
   logic [63:0]            rsp_tdata_ff;
   logic [2:0]             rsp_tuser_ff;
   logic                   accept;
   logic                   window_hit;
   logic                   load_out;
   logic                   reading_ok;
   logic                   div_done;
   logic [QUOT_WIDTH-1:0]  quotient;
   logic [QUOT_WIDTH-1:0]  moisture;
   chan_type               soil_next;
   chan_type               air_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign window_hit = accept && req_tlast;

   dcmfm_counter u_soil (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .level      (req_tdata[0]),
      .window_end (req_tlast),
      .limit      (limit_ff),
      .chan_next  (soil_next)
   );

   dcmfm_counter u_air (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .level      (req_tdata[1]),
      .window_end (req_tlast),
      .limit      (limit_ff),
      .chan_next  (air_next)
   );

   dcmfm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .soil     (snap_soil_ff),
      .air      (snap_air_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // csr
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_LIMIT) begin
         csr_prdata = 32'(limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_LIMIT)) begin
         limit_ff <= csr_pwdata[LIMIT_WIDTH-1:0];
      end
   end

   // sequencer
   always_comb begin
      load_out = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (window_hit) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         start_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= window_hit;
         if (load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (window_hit) begin
         snap_soil_ff      <= soil_next.count;
         snap_air_ff       <= air_next.count;
         snap_soil_flag_ff <= soil_next.flag;
         snap_air_flag_ff  <= air_next.flag;
      end
   end

   // result register
   always_comb begin
      reading_ok = (snap_soil_ff != '0) && (snap_air_ff != '0);
      moisture   = reading_ok ? quotient : '0;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tdata_ff <= {2'b00, moisture, FIELD_WIDTH'(snap_air_ff),
                          FIELD_WIDTH'(snap_soil_ff)};
         rsp_tuser_ff <= {reading_ok, snap_air_flag_ff, snap_soil_flag_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ----- verif/dual_channel_moisture_frequency_meter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_channel_moisture_frequency_meter_tb
// Streams oscillator sample ticks into the meter under several overflow limits.
// A scoreboard tracks edge counts, sticky flags and the moisture ratio for
// each window and checks every rsp transaction field by field. Both sides
// idle at random. One long rsp hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module dual_channel_moisture_frequency_meter_tb
   import dcmfm_pkg::*;
();

   localparam int REG_OVERFLOW_LIMIT = 0;
   localparam int REG_SPARE          = 1;   // unmapped, writes must be dropped
   localparam int CYCLE_LIMIT        = 400000;
   localparam int DRAIN_CYCLES       = 40;
   localparam int HOLD_CYCLES        = 400;
   localparam int PHASE_ITEMS        = 75;

   typedef struct {
      logic [FIELD_WIDTH-1:0] soil_count;
      logic [FIELD_WIDTH-1:0] air_count;
      logic                   soil_ovf;
      logic                   air_ovf;
      logic                   valid;
      logic [QUOT_WIDTH-1:0]  moisture;
   } reading_type;

   class moisture_scoreboard;
      logic [LIMIT_WIDTH-1:0] limit;
      logic [COUNT_WIDTH-1:0] edges [2];   // index 0 soil, 1 air
      bit                     over [2];
      bit                     prev [2];
      reading_type            readings_due [$];
      int                     errors;
      int                     ticks;
      int                     windows;
      int                     valid_seen;
      int                     flags_seen;

      function new();
         limit = LIMIT_RESET;
         for (int c = 0; c < 2; c++) begin
            edges[c] = '0;
            over[c]  = 0;
            prev[c]  = 1;
         end
         errors = 0;
         ticks = 0;
         windows = 0;
         valid_seen = 0;
         flags_seen = 0;
      endfunction

      function void write_reg(int idx, logic [31:0] value);
         if (idx == REG_OVERFLOW_LIMIT) limit = value[LIMIT_WIDTH-1:0];
      endfunction

      function int pending();
         return readings_due.size();
      endfunction

      function void note_tick(bit soil, bit air, bit wend);
         bit [1:0]          lvl;
         reading_type       r;
         longint unsigned   num;
         lvl = {air, soil};
         ticks++;
         for (int c = 0; c < 2; c++) begin
            if (!prev[c] && lvl[c]) begin
               if (edges[c] != COUNT_MAX) edges[c] = edges[c] + COUNT_WIDTH'(1);
               if (edges[c] > limit) over[c] = 1;
            end
            prev[c] = lvl[c];
         end
         if (!wend) return;
         r.soil_count = FIELD_WIDTH'(edges[0]);
         r.air_count  = FIELD_WIDTH'(edges[1]);
         r.soil_ovf   = over[0];
         r.air_ovf    = over[1];
         r.valid      = (edges[0] != 0) && (edges[1] != 0);
         r.moisture   = '0;
         if (r.valid && edges[0] < edges[1]) begin
            num = 64'(10000) * 64'(edges[1] - edges[0]);
            r.moisture = QUOT_WIDTH'(num / 64'(edges[1]));
         end
         readings_due.push_back(r);
         windows++;
         if (r.valid) valid_seen++;
         if (r.soil_ovf || r.air_ovf) flags_seen++;
         for (int c = 0; c < 2; c++) begin
            edges[c] = '0;
            over[c]  = 0;
         end
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [63:0] data, logic [2:0] user);
         reading_type r;
         if (readings_due.size() == 0) begin
            $display("%0t: rsp transaction with no reading pending, tdata %h tuser %b",
                     $time, data, user);
            errors++;
            return;
         end
         r = readings_due.pop_front();
         compare_field("soil_count", r.soil_count, data[23:0]);
         compare_field("air_count", r.air_count, data[47:24]);
         compare_field("moisture", r.moisture, data[61:48]);
         compare_field("soil_overflow", r.soil_ovf, user[0]);
         compare_field("air_overflow", r.air_ovf, user[1]);
         compare_field("reading_valid", r.valid, user[2]);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   moisture_scoreboard sb = new();
   int  cycles = 0;
   bit  tx_busy = 0;
   bit  rsp_busy = 1;
   bit  hold_request = 0;
   bit  soil_lvl = 1;
   bit  air_lvl = 1;

   dual_channel_moisture_frequency_meter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings outstanding", cycles, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_tick(input bit soil, input bit air, input bit wend);
      int gap;
      gap = tx_busy ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {6'b0, air, soil};
      req_tlast  <= wend;
      do @(posedge clock); while (!req_tready);
      sb.note_tick(soil, air, wend);
   endtask

   // toggle rates are in sixteenths per tick
   task automatic send_window(input int len, input int soil_rate, input int air_rate);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(1, 16) <= soil_rate) soil_lvl = !soil_lvl;
         if ($urandom_range(1, 16) <= air_rate) air_lvl = !air_lvl;
         send_tick(soil_lvl, air_lvl, i == len - 1);
      end
   endtask

   task automatic settle();
      req_tvalid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [31:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= 3'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic run_phase(input int n_items);
      int sent;
      int len;
      int sr;
      int ar;
      sent = 0;
      while (sent < n_items) begin
         tx_busy = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 19))
            0:             len = $urandom_range(60, 120);
            1, 2, 3, 4, 5: len = $urandom_range(17, 40);
            default:       len = $urandom_range(1, 16);
         endcase
         sr = $urandom_range(0, 16);
         ar = ($urandom_range(0, 2) != 0) ? $urandom_range(sr, 16) : $urandom_range(0, 16);
         send_window(len, sr, ar);
         sent += len;
      end
   endtask

   // result side
   initial begin : rsp_side
      int gap;
      rsp_tready <= 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = rsp_busy ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
               rsp_tready <= 0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tuser);
         if ($urandom_range(0, 7) == 0) rsp_busy = !rsp_busy;
      end
   end

   initial begin
      reset       <= 1;
      req_tvalid  <= 0;
      req_tdata   <= '0;
      req_tlast   <= 0;
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty window, equal counts, missing soil, a ratio, missing air, clamp
      tx_busy = 1;
      send_tick(1, 1, 1);
      send_tick(0, 0, 0);
      send_tick(1, 1, 1);
      send_tick(0, 0, 0);
      send_tick(0, 1, 0);
      send_tick(0, 0, 0);
      send_tick(0, 1, 1);
      send_tick(0, 0, 0);
      send_tick(1, 1, 0);
      send_tick(0, 0, 0);
      send_tick(0, 1, 0);
      send_tick(0, 0, 0);
      send_tick(0, 1, 1);
      send_tick(1, 0, 0);
      send_tick(0, 0, 0);
      send_tick(1, 0, 1);
      send_tick(0, 0, 0);
      send_tick(1, 1, 0);
      send_tick(0, 0, 0);
      send_tick(1, 0, 1);
      settle();
      csr_write(REG_SPARE, 32'd5);
      csr_write(REG_OVERFLOW_LIMIT, 32'd0);
      send_tick(0, 0, 0);
      send_tick(1, 0, 1);
      settle();
      soil_lvl = 1;
      air_lvl = 0;

      run_phase(PHASE_ITEMS);
      settle();
      csr_write(REG_OVERFLOW_LIMIT, 32'h00FF_FFFF);
      run_phase(PHASE_ITEMS);
      settle();

      // back-to-back window ends against a stalled rsp side
      csr_write(REG_OVERFLOW_LIMIT, $urandom_range(1, 20));
      hold_request = 1;
      tx_busy = 0;
      repeat (24) send_window(1, 8, 12);
      run_phase(60);
      settle();

      csr_write(REG_OVERFLOW_LIMIT, 32'd1);
      run_phase(PHASE_ITEMS);
      settle();
      csr_write(REG_OVERFLOW_LIMIT, $urandom_range(2, 40));
      run_phase(PHASE_ITEMS);
      settle();
      // upper bits beyond the register width are dropped
      csr_write(REG_OVERFLOW_LIMIT, 32'hFF00_0003);
      run_phase(PHASE_ITEMS);
      settle();

      $display("covered %0d ticks in %0d windows over 7 limit settings and one long rsp stall",
               sb.ticks, sb.windows);
      $display("readings: %0d valid, %0d with an overflow flag, %0d mismatches",
               sb.valid_seen, sb.flags_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
